// ----- hdl/sorted_symbol_frequency_counter_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros for the sorted symbol frequency counter
// Clocked on clk, quiet while arst_n is low.
// -----------------------------------------------------------------------------
`ifndef SORTED_SYMBOL_FREQUENCY_COUNTER_MACROS_SVH
`define SORTED_SYMBOL_FREQUENCY_COUNTER_MACROS_SVH

// antecedent and consequent in the same cycle
`define SSFC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the cycle after the antecedent
`define SSFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/ssfc_pkg.sv -----
// -----------------------------------------------------------------------------
// ssfc_pkg
// Shared codes, widths and types of the sorted symbol frequency counter.
// -----------------------------------------------------------------------------
package ssfc_pkg;

	localparam int SYMBOL_W = 32;
	localparam int COUNT_W  = 32;

	localparam int DEF_TABLE_DEPTH  = 64;
	localparam int DEF_SYMBOL_BYTES = 4;

	// request kinds on the slave tuser
	localparam logic [1:0] REQ_ADD  = 2'd0;
	localparam logic [1:0] REQ_GET  = 2'd1;
	localparam logic [1:0] REQ_DUMP = 2'd2;

	// broadcast command to every cell of the chain
	typedef struct packed {
		logic compare;   // latch less / hit flags against the broadcast key
		logic hit_inc;   // bump the count of the hit cell
		logic insert;    // open a slot and write the broadcast key
		logic rotate;    // move every valid entry one place towards cell 0
	} ssfc_cmd_t;

	// per-cell status back to the controller
	typedef struct packed {
		logic less;      // entry valid and below the broadcast key
		logic hit;       // entry valid and equal to the broadcast key
	} ssfc_flags_t;

endpackage

// ----- hdl/ssfc_cell.sv -----
// -----------------------------------------------------------------------------
// ssfc_cell
// One slot of the sorted chain: a key, its count, and compare flags.
// -----------------------------------------------------------------------------
module ssfc_cell #(
	parameter int INDEX       = 0,
	parameter int KEY_BITS    = 32,
	parameter int TABLE_DEPTH = 64,
	localparam int USED_W     = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ssfc_pkg::ssfc_cmd_t         cmd,
	input  logic [KEY_BITS-1:0]         new_key,
	input  logic [USED_W-1:0]           used,
	input  logic                        prev_less,
	input  logic [KEY_BITS-1:0]         prev_key,
	input  logic [ssfc_pkg::COUNT_W-1:0] prev_count,
	input  logic [KEY_BITS-1:0]         next_key,
	input  logic [ssfc_pkg::COUNT_W-1:0] next_count,
	input  logic [KEY_BITS-1:0]         wrap_key,
	input  logic [ssfc_pkg::COUNT_W-1:0] wrap_count,
	output logic [KEY_BITS-1:0]         key,
	output logic [ssfc_pkg::COUNT_W-1:0] count,
	output ssfc_pkg::ssfc_flags_t       flags
);
	import ssfc_pkg::*;

	localparam logic [USED_W-1:0] IDX      = USED_W'(INDEX);
	localparam logic [USED_W-1:0] IDX_NEXT = USED_W'(INDEX + 1);

	logic [KEY_BITS-1:0] key_q;
	logic [COUNT_W-1:0]  count_q;
	logic                less_q;
	logic                hit_q;
	logic                valid;

	assign valid = used > IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			less_q <= 1'b0;
			hit_q  <= 1'b0;
		end else if (cmd.compare) begin
			less_q <= valid && (key_q < new_key);
			hit_q  <= valid && (key_q == new_key);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hit_inc && hit_q) begin
			// saturate at all ones
			if (count_q != '1) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end else if (cmd.insert && !less_q) begin
			if (prev_less) begin
				key_q   <= new_key;
				count_q <= COUNT_W'(1);
			end else begin
				key_q   <= prev_key;
				count_q <= prev_count;
			end
		end else if (cmd.rotate && valid) begin
			if (IDX_NEXT < used) begin
				key_q   <= next_key;
				count_q <= next_count;
			end else begin
				key_q   <= wrap_key;
				count_q <= wrap_count;
			end
		end
	end

	assign key        = key_q;
	assign count      = count_q;
	assign flags.less = less_q;
	assign flags.hit  = hit_q;

endmodule

// ----- hdl/sorted_symbol_frequency_counter.sv -----
// -----------------------------------------------------------------------------
// sorted_symbol_frequency_counter
// Symbol occurrence table kept in ascending key order in a chain of cells.
// -----------------------------------------------------------------------------
// Requests enter on the slave stream: s_tuser holds the request kind (add,
// get, dump) and s_tdata the symbol, left-aligned and zero-padded. Results
// leave on the master stream: m_tdata holds symbol and count, m_tuser the
// table-full flag, m_tlast marks the final word of a request.
// One request is worked on at a time. An add or get is accepted, compared in
// every cell at once (ST_CMP), applied (ST_UPD), and its result loaded into
// the output register (ST_RES) before the next request can be taken.
// A dump sends one word per stored entry (a single word for an empty table),
// each when the output register is free; the entries are read at cell 0
// while the chain rotates, and after a full turn the table is back in its
// order. An unknown request kind is dropped and the block stays ready.
// Reset empties the table at once; no clearing pass is needed.
// A stalled receiver holds the output register; the block waits with the next
// result and takes no new request until that result is in the register.
// -----------------------------------------------------------------------------
module sorted_symbol_frequency_counter #(
	parameter int TABLE_DEPTH  = ssfc_pkg::DEF_TABLE_DEPTH,
	parameter int SYMBOL_BYTES = ssfc_pkg::DEF_SYMBOL_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // symbol
	input  logic [1:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_symbol, out_count
	output logic        m_tuser,   // table_full
	output logic        m_tlast    // last
);
	import ssfc_pkg::*;

	localparam int KEY_BITS = 8 * SYMBOL_BYTES;
	localparam int USED_W   = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CMP  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_RES  = 3'd3;
	localparam logic [2:0] ST_DUMP = 3'd4;

	logic [2:0]          state_q;
	logic [1:0]          req_q;
	logic [KEY_BITS-1:0] key_q;
	logic [USED_W-1:0]   used_q;
	logic [USED_W-1:0]   dump_cnt_q;
	logic                ins_q;
	logic                full_q;

	logic                out_valid_q;
	logic [SYMBOL_W-1:0] out_symbol_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic                out_full_q;
	logic                out_last_q;

	logic                accept;
	logic                out_free;
	logic [KEY_BITS-1:0] canon;
	logic                table_is_full;
	logic                any_hit;
	logic [COUNT_W-1:0]  sel_count;
	logic                dump_last;
	ssfc_cmd_t           cmd;

	logic [KEY_BITS-1:0] cell_key   [TABLE_DEPTH];
	logic [COUNT_W-1:0]  cell_count [TABLE_DEPTH];
	ssfc_flags_t         cell_flags [TABLE_DEPTH];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// drop every byte after the first zero byte, scanning from the top
	always_comb begin
		logic [KEY_BITS-1:0] raw;
		logic                alive;
		logic [7:0]          sym_byte;
		raw   = KEY_BITS'(s_tdata);
		alive = 1'b1;
		canon = '0;
		for (int i = 0; i < SYMBOL_BYTES; i++) begin
			sym_byte = raw[KEY_BITS-8*(i+1) +: 8];
			if (sym_byte == 8'd0) begin
				alive = 1'b0;
			end
			if (alive) begin
				canon[KEY_BITS-8*(i+1) +: 8] = sym_byte;
			end
		end
	end

	assign table_is_full = (used_q == USED_W'(TABLE_DEPTH));

	always_comb begin
		any_hit   = 1'b0;
		sel_count = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			any_hit = any_hit | cell_flags[i].hit;
			if (cell_flags[i].hit) begin
				sel_count = sel_count | cell_count[i];
			end
		end
	end

	assign dump_last = (dump_cnt_q == used_q - USED_W'(1));

	always_comb begin
		cmd         = '0;
		cmd.compare = (state_q == ST_CMP);
		cmd.hit_inc = (state_q == ST_UPD) && (req_q == REQ_ADD);
		cmd.insert  = (state_q == ST_UPD) && (req_q == REQ_ADD) && !any_hit && !table_is_full;
		cmd.rotate  = (state_q == ST_DUMP) && out_free && (used_q != '0);
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		logic                prev_less;
		logic [KEY_BITS-1:0] prev_key;
		logic [COUNT_W-1:0]  prev_count;
		logic [KEY_BITS-1:0] next_key;
		logic [COUNT_W-1:0]  next_count;

		if (g == 0) begin : g_head
			assign prev_less  = 1'b1;
			assign prev_key   = '0;
			assign prev_count = '0;
		end else begin : g_body
			assign prev_less  = cell_flags[g-1].less;
			assign prev_key   = cell_key[g-1];
			assign prev_count = cell_count[g-1];
		end

		if (g == TABLE_DEPTH - 1) begin : g_tail
			assign next_key   = '0;
			assign next_count = '0;
		end else begin : g_inner
			assign next_key   = cell_key[g+1];
			assign next_count = cell_count[g+1];
		end

		ssfc_cell #(
			.INDEX      (g),
			.KEY_BITS   (KEY_BITS),
			.TABLE_DEPTH(TABLE_DEPTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.new_key   (key_q),
			.used      (used_q),
			.prev_less (prev_less),
			.prev_key  (prev_key),
			.prev_count(prev_count),
			.next_key  (next_key),
			.next_count(next_count),
			.wrap_key  (cell_key[0]),
			.wrap_count(cell_count[0]),
			.key       (cell_key[g]),
			.count     (cell_count[g]),
			.flags     (cell_flags[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			dump_cnt_q  <= '0;
			req_q       <= REQ_ADD;
			ins_q       <= 1'b0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q <= s_tuser;
						if (s_tuser == REQ_ADD || s_tuser == REQ_GET) begin
							state_q <= ST_CMP;
						end else if (s_tuser == REQ_DUMP) begin
							dump_cnt_q <= '0;
							state_q    <= ST_DUMP;
						end
					end
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					ins_q  <= cmd.insert;
					full_q <= (req_q == REQ_ADD) && !any_hit && table_is_full;
					if (cmd.insert) begin
						used_q <= used_q + USED_W'(1);
					end
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_DUMP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						dump_cnt_q  <= dump_cnt_q + USED_W'(1);
						if (used_q == '0 || dump_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// registered request key and payload of the output word
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= canon;
		end
		if (state_q == ST_RES && out_free) begin
			out_symbol_q <= SYMBOL_W'(key_q);
			out_full_q   <= full_q;
			out_last_q   <= 1'b1;
			if (any_hit) begin
				out_count_q <= sel_count;
			end else begin
				out_count_q <= ins_q ? COUNT_W'(1) : '0;
			end
		end else if (state_q == ST_DUMP && out_free) begin
			out_full_q <= 1'b0;
			if (used_q == '0) begin
				out_symbol_q <= '0;
				out_count_q  <= '0;
				out_last_q   <= 1'b1;
			end else begin
				out_symbol_q <= SYMBOL_W'(cell_key[0]);
				out_count_q  <= cell_count[0];
				out_last_q   <= dump_last;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_count_q, out_symbol_q};
	assign m_tuser  = out_full_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- hdl/ssfc_checker.sv -----
// -----------------------------------------------------------------------------
// ssfc_checker
// Port-level checks of the sorted symbol frequency counter, bound to the top.
// -----------------------------------------------------------------------------
`include "sorted_symbol_frequency_counter_macros.svh"

module ssfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);
	import ssfc_pkg::*;

	logic stalled;
	logic busy_req;

	assign stalled  = m_tvalid && !m_tready;
	assign busy_req = s_tvalid && s_tready &&
		(s_tuser == REQ_ADD || s_tuser == REQ_GET || s_tuser == REQ_DUMP);

	// hold a stalled word
	`SSFC_ASSERT_NEXT(a_hold_valid, stalled, m_tvalid, "output word dropped while stalled")
	`SSFC_ASSERT_NEXT(a_hold_data, stalled, $stable(m_tdata) && $stable(m_tlast), "stalled word changed")
	// a valid request keeps the block busy for at least the next cycle
	`SSFC_ASSERT_NEXT(a_busy, busy_req, !s_tready, "request taken while the previous one runs")
	// a refused add ends its request and reports no count
	`SSFC_ASSERT_SAME(a_full_word, m_tvalid && m_tuser, m_tlast && (m_tdata[63:32] == 32'd0), "full flag on a word with a count or without last")

endmodule

bind sorted_symbol_frequency_counter ssfc_checker u_ssfc_checker (.*);

// ----- tb/sorted_symbol_frequency_counter_checker.sv -----
// -----------------------------------------------------------------------------
// sorted_symbol_frequency_counter_checker
// Watches both streams of the counter, keeps its own sorted table and checks
// every result word against the words that the accepted requests call for.
// -----------------------------------------------------------------------------
module sorted_symbol_frequency_counter_checker #(
	parameter int TABLE_DEPTH  = ssfc_pkg::DEF_TABLE_DEPTH,
	parameter int SYMBOL_BYTES = ssfc_pkg::DEF_SYMBOL_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // symbol
	input  logic [1:0]  s_tuser,   // req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,   // out_symbol, out_count
	input  logic        m_tuser,   // table_full
	input  logic        m_tlast,   // last
	output int          mismatches,
	output int          pending,
	output int          requests,
	output int          words_seen,
	output int          dumps,
	output int          refusals
);

	import ssfc_pkg::*;

	localparam int KEY_BITS = 8 * SYMBOL_BYTES;

	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic [COUNT_W-1:0]  count;
		logic                full;
		logic                last;
	} freq_word_t;

	logic [63:0]        table_keys   [TABLE_DEPTH];
	logic [COUNT_W-1:0] table_counts [TABLE_DEPTH];
	int                 table_used = 0;
	freq_word_t         expected_words[$];

	initial begin
		mismatches = 0;
		pending    = 0;
		requests   = 0;
		words_seen = 0;
		dumps      = 0;
		refusals   = 0;
	end

	// clear every byte from the first zero byte down, as a string ends there
	function automatic logic [63:0] canonical_key(input logic [31:0] raw);
		logic [63:0] key;
		logic [63:0] keep;
		logic [7:0]  b;
		int          sh;
		key = {32'd0, raw};
		if (KEY_BITS < 64)
			key = key & ((64'd1 << KEY_BITS) - 64'd1);
		keep = '0;
		for (int i = 0; i < SYMBOL_BYTES; i++) begin
			sh = KEY_BITS - 8 * (i + 1);
			b  = key[sh +: 8];
			if (b == 8'd0)
				break;
			keep[sh +: 8] = b;
		end
		return keep;
	endfunction

	function automatic int first_not_below(input logic [63:0] k);
		int p;
		p = 0;
		while (p < table_used && table_keys[p] < k)
			p++;
		return p;
	endfunction

	task automatic push_word(input logic [31:0] sym, input logic [31:0] cnt,
	                         input logic full, input logic last);
		freq_word_t w;
		w.symbol = sym;
		w.count  = cnt;
		w.full   = full;
		w.last   = last;
		expected_words.push_back(w);
	endtask

	task automatic predict_words(input logic [1:0] kind, input logic [31:0] raw);
		logic [63:0] key;
		int          pos;
		key = canonical_key(raw);
		pos = first_not_below(key);
		case (kind)
			REQ_ADD: begin
				requests++;
				if (pos < table_used && table_keys[pos] == key) begin
					// saturate rather than wrap
					if (table_counts[pos] != '1)
						table_counts[pos] = table_counts[pos] + 1;
					push_word(key[31:0], table_counts[pos], 1'b0, 1'b1);
				end else if (table_used >= TABLE_DEPTH) begin
					push_word(key[31:0], '0, 1'b1, 1'b1);
					refusals++;
				end else begin
					for (int i = table_used; i > pos; i--) begin
						table_keys[i]   = table_keys[i - 1];
						table_counts[i] = table_counts[i - 1];
					end
					table_keys[pos]   = key;
					table_counts[pos] = 1;
					table_used++;
					push_word(key[31:0], 32'd1, 1'b0, 1'b1);
				end
			end
			REQ_GET: begin
				requests++;
				if (pos < table_used && table_keys[pos] == key)
					push_word(key[31:0], table_counts[pos], 1'b0, 1'b1);
				else
					push_word(key[31:0], '0, 1'b0, 1'b1);
			end
			REQ_DUMP: begin
				requests++;
				dumps++;
				if (table_used == 0)
					push_word('0, '0, 1'b0, 1'b1);
				else
					for (int i = 0; i < table_used; i++)
						push_word(table_keys[i][31:0], table_counts[i], 1'b0,
						          (i + 1 == table_used));
			end
			default: begin
				// unknown kind: dropped by the block, nothing to predict
			end
		endcase
	endtask

	always @(posedge clk) begin
		freq_word_t w;
		if (arst_n) begin
			// results come from earlier requests, so check before predicting
			if (m_tvalid && m_tready) begin
				words_seen++;
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected: symbol %h count %h",
					       m_tdata[31:0], m_tdata[63:32]);
					mismatches++;
				end else begin
					w = expected_words.pop_front();
					if (m_tdata[31:0] !== w.symbol) begin
						$error("out_symbol: expected %h, got %h", w.symbol, m_tdata[31:0]);
						mismatches++;
					end
					if (m_tdata[63:32] !== w.count) begin
						$error("out_count: expected %h, got %h", w.count, m_tdata[63:32]);
						mismatches++;
					end
					if (m_tuser !== w.full) begin
						$error("table_full: expected %b, got %b", w.full, m_tuser);
						mismatches++;
					end
					if (m_tlast !== w.last) begin
						$error("last: expected %b, got %b", w.last, m_tlast);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_words(s_tuser, s_tdata);
			pending = expected_words.size();
		end
	end

endmodule

// ----- tb/sorted_symbol_frequency_counter_test.sv -----
// -----------------------------------------------------------------------------
// sorted_symbol_frequency_counter_test
// Drives add, get and dump requests into the counter: a directed opening on
// empty symbols, junk after zero bytes and an empty dump, then random requests
// over a small symbol pool that later give way to fresh symbols until the
// table fills. Both streams idle at random; the checker gives the verdict.
// -----------------------------------------------------------------------------
module sorted_symbol_frequency_counter_test;

	import ssfc_pkg::*;

	localparam logic [1:0] REQ_UNUSED  = 2'd3;
	localparam int         RANDOM_REQS = 250;
	localparam int         POOL_SIZE   = 16;
	localparam int         CYCLE_LIMIT = 400000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;    // symbol
	logic [1:0]  s_tuser  = '0;    // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;          // out_symbol, out_count
	logic        m_tuser;          // table_full
	logic        m_tlast;          // last

	logic        calm = 1'b0;
	int          cycles = 0;
	logic [31:0] symbol_pool [POOL_SIZE];

	int mismatches, pending, requests, words_seen, dumps, refusals;

	sorted_symbol_frequency_counter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	sorted_symbol_frequency_counter_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending),
		.requests   (requests),
		.words_seen (words_seen),
		.dumps      (dumps),
		.refusals   (refusals)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycles, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// stall the receiver now and then, except in the calm stretch
	always @(negedge clk)
		m_tready <= calm || ($urandom_range(0, 99) >= 9);

	// hold the word until it is taken; starts and ends at a falling edge
	task automatic send_request(input logic [1:0] kind, input logic [31:0] sym);
		while (!calm && $urandom_range(0, 99) < 9) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= sym;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_symbol(input int fresh_pct);
		logic [31:0] s;
		int          b;
		if ($urandom_range(0, 99) < fresh_pct) begin
			s = $urandom();
			// a zero byte at a random place cuts the symbol short
			if ($urandom_range(0, 3) == 0) begin
				b = $urandom_range(0, 3);
				s[8 * b +: 8] = 8'h00;
			end
		end else begin
			s = symbol_pool[$urandom_range(0, POOL_SIZE - 1)];
			if (s[15:8] == 8'h00 && $urandom_range(0, 1) == 1)
				s[7:0] = 8'($urandom());
		end
		return s;
	endfunction

	initial begin
		logic [31:0] s;
		logic [1:0]  kind;
		int          len;
		int          r;
		int          n;

		for (int i = 0; i < POOL_SIZE; i++) begin
			len = $urandom_range(0, 4);
			s   = '0;
			for (int j = 0; j < len; j++)
				s[31 - 8 * j -: 8] = 8'($urandom_range(1, 255));
			symbol_pool[i] = s;
		end

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed opening
		send_request(REQ_DUMP, 32'h0000_0000);
		send_request(REQ_GET,  32'h0000_0000);
		send_request(REQ_ADD,  32'h4100_0000);
		send_request(REQ_ADD,  32'h4100_0000);
		send_request(REQ_ADD,  32'h0000_0000);
		send_request(REQ_ADD,  32'hFFFF_FFFF);
		send_request(REQ_ADD,  32'h4100_4243);
		send_request(REQ_ADD,  32'h00FF_FFFF);
		send_request(REQ_ADD,  32'h4142_0000);
		send_request(REQ_GET,  32'h4142_0099);
		send_request(REQ_GET,  32'hFFFF_FFFF);
		send_request(REQ_GET,  32'h1234_5678);
		send_request(REQ_UNUSED, 32'hA5A5_A5A5);
		send_request(REQ_ADD,  32'h0101_0101);
		send_request(REQ_ADD,  32'h8000_0000);
		send_request(REQ_ADD,  32'h7F80_0001);
		send_request(REQ_DUMP, 32'hFFFF_FFFF);
		send_request(REQ_UNUSED, 32'h5A5A_5A5A);
		send_request(REQ_GET,  32'h0000_0000);
		send_request(REQ_GET,  32'h4100_0000);

		// random part: pool-heavy first so counts climb, then fresh symbols
		// until the table is full and new adds are refused
		n = 0;
		while (n < RANDOM_REQS) begin
			calm <= (n >= 140 && n < 190);
			r = $urandom_range(0, 99);
			if (r < 4)
				kind = REQ_UNUSED;
			else if (r < 10)
				kind = REQ_DUMP;
			else if (r < 70)
				kind = REQ_ADD;
			else
				kind = REQ_GET;
			send_request(kind, pick_symbol((n < RANDOM_REQS / 2) ? 30 : 75));
			if (kind != REQ_UNUSED)
				n++;
		end
		send_request(REQ_DUMP, $urandom());
		s_tvalid <= 1'b0;
		calm     <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);

		$display("Run covered %0d requests (%0d dumps), %0d result words checked,",
		         requests, dumps, words_seen);
		$display("and %0d adds refused by a full table.", refusals);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ssfc_pkg.sv
hdl/ssfc_cell.sv
hdl/sorted_symbol_frequency_counter.sv
hdl/ssfc_checker.sv
tb/sorted_symbol_frequency_counter_checker.sv
tb/sorted_symbol_frequency_counter_test.sv
